// ===== design/hps_pkg.sv =====
package hps_pkg;

  localparam int MODE_W   = 2;
  localparam int EFFECT_W = 2;
  localparam int COUNT_W  = 8;
  localparam int LEN_W    = 16;
  localparam int STEP_W   = LEN_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 16;

  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLAY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;

  localparam logic [EFFECT_W-1:0] EFF_TICK   = 2'd0;
  localparam logic [EFFECT_W-1:0] EFF_WARN   = 2'd1;
  localparam logic [EFFECT_W-1:0] EFF_EXPIRE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_DUR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_DUR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPIRE_DUR = 2'd2;

  localparam logic [LEN_W-1:0] TICK_DUR_RST   = 16'd30;
  localparam logic [LEN_W-1:0] WARN_DUR_RST   = 16'd80;
  localparam logic [LEN_W-1:0] EXPIRE_DUR_RST = 16'd500;

endpackage

// ===== design/hps_ram.sv =====
module hps_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/haptic_pattern_sequencer_top.sv =====
// Channel   Signals                              Transfer when
// input     in_valid, in_ready, mode, effect,    in_valid & in_ready
//           repeat_count, gap_length
// output    out_valid, out_ready, motor_on,      out_valid & out_ready
//           busy_res
// config    wr_en, wr_index, wr_data             wr_en
//
// Tick, stop or unknown mode: IDLE then DELIVER; a tick that ends a step passes
// through START, LOAD and DELIVER, or START and DELIVER when no step is left.
// Play: FILL builds the list, one step position per cycle (up to 4 per unit),
// ending early once all STEP_SLOTS slots are full; the single write port of the
// step memory sets that rate. Then START, LOAD when a step starts, and DELIVER.
// Reset clears the control state; the step memory is not cleared.
// A result waits in the output register; the next item is taken meanwhile.
module haptic_pattern_sequencer_top
  import hps_pkg::*;
#(
  parameter int STEP_SLOTS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MODE_W-1:0]    mode,
  input  logic [EFFECT_W-1:0]  effect,
  input  logic [COUNT_W-1:0]   repeat_count,
  input  logic [LEN_W-1:0]     gap_length,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 motor_on,
  output logic                 busy_res,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  localparam int AW = $clog2(STEP_SLOTS);
  localparam int TW = $clog2(STEP_SLOTS + 1);
  localparam logic [TW-1:0] SLOTS_CNT = TW'(STEP_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_START,
    ST_LOAD,
    ST_DELIVER
  } state_t;

  state_t state;

  logic [LEN_W-1:0]    tick_duration;
  logic [LEN_W-1:0]    warn_duration;
  logic [LEN_W-1:0]    expire_duration;

  logic [TW-1:0]       step_total;
  logic [TW-1:0]       step_index;
  logic [LEN_W-1:0]    time_left;
  logic                motor_level;

  logic [EFFECT_W-1:0] play_effect;
  logic [COUNT_W-1:0]  play_count;
  logic [LEN_W-1:0]    play_gap;
  logic [COUNT_W-1:0]  unit_cnt;
  logic [1:0]          phase;

  logic [1:0]          unit_steps;
  logic                unit_level;
  logic [LEN_W-1:0]    unit_len;
  logic                at_end;
  logic                last_unit;
  logic                list_full;
  logic                push_level;
  logic [LEN_W-1:0]    push_len;
  logic                mem_we;
  logic                mem_re;
  logic [STEP_W-1:0]   mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_duration   <= TICK_DUR_RST;
      warn_duration   <= WARN_DUR_RST;
      expire_duration <= EXPIRE_DUR_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TICK_DUR:   tick_duration   <= wr_data;
        REG_WARN_DUR:   warn_duration   <= wr_data;
        REG_EXPIRE_DUR: expire_duration <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unit_steps = 2'd0;
    unit_len   = tick_duration;
    case (play_effect)
      EFF_TICK: begin
        unit_steps = 2'd1;
        unit_len   = tick_duration;
      end
      EFF_WARN: begin
        unit_steps = 2'd3;
        unit_len   = warn_duration;
      end
      EFF_EXPIRE: begin
        unit_steps = 2'd1;
        unit_len   = expire_duration;
      end
      default: ;
    endcase
    unit_level = !(play_effect == EFF_WARN && phase == 2'd1);
    at_end     = (phase == unit_steps);
    last_unit  = ({1'b0, unit_cnt} + 9'd1) == {1'b0, play_count};
    list_full  = (step_total == SLOTS_CNT);
    push_len   = at_end ? play_gap : unit_len;
    push_level = at_end ? 1'b0 : unit_level;
    mem_we     = (state == ST_FILL) && !list_full && !(at_end && last_unit)
                 && (push_len != '0);
    mem_re     = (state == ST_START) && (step_index < step_total);
  end

  hps_ram #(
    .WIDTH (STEP_W),
    .DEPTH (STEP_SLOTS)
  ) u_step_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (step_total[AW-1:0]),
    .wdata ({push_level, push_len}),
    .re    (mem_re),
    .raddr (step_index[AW-1:0]),
    .rdata (mem_rdata)
  );

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step_total  <= '0;
      step_index  <= '0;
      time_left   <= '0;
      motor_level <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DELIVER) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            unique case (mode)
              MODE_TICK: begin
                if (time_left != '0) begin
                  time_left <= time_left - 16'd1;
                  state     <= (time_left == 16'd1) ? ST_START : ST_DELIVER;
                end else begin
                  state <= ST_DELIVER;
                end
              end
              MODE_PLAY: begin
                step_total  <= '0;
                step_index  <= '0;
                time_left   <= '0;
                motor_level <= 1'b0;
                play_effect <= effect;
                play_count  <= repeat_count;
                play_gap    <= gap_length;
                unit_cnt    <= '0;
                phase       <= 2'd0;
                state       <= (repeat_count == '0) ? ST_START : ST_FILL;
              end
              MODE_STOP: begin
                step_total  <= '0;
                step_index  <= '0;
                time_left   <= '0;
                motor_level <= 1'b0;
                state       <= ST_DELIVER;
              end
              default: state <= ST_DELIVER;
            endcase
          end
        end
        ST_FILL: begin
          if (mem_we) begin
            step_total <= step_total + TW'(1);
          end
          if (list_full || (at_end && last_unit)) begin
            state <= ST_START;
          end else if (at_end) begin
            unit_cnt <= unit_cnt + 8'd1;
            phase    <= 2'd0;
          end else begin
            phase <= phase + 2'd1;
          end
        end
        ST_START: begin
          if (step_index < step_total) begin
            state <= ST_LOAD;
          end else begin
            motor_level <= 1'b0;
            time_left   <= '0;
            state       <= ST_DELIVER;
          end
        end
        ST_LOAD: begin
          motor_level <= mem_rdata[STEP_W-1];
          time_left   <= mem_rdata[LEN_W-1:0];
          step_index  <= step_index + TW'(1);
          state       <= ST_DELIVER;
        end
        ST_DELIVER: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            motor_on  <= motor_level;
            busy_res  <= (step_index < step_total);
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_index_within_total: assert property (@(posedge clk) disable iff (rst)
    step_index <= step_total)
    else $error("step index beyond stored steps");

  a_total_within_slots: assert property (@(posedge clk) disable iff (rst)
    step_total <= SLOTS_CNT)
    else $error("step count beyond slot count");

  a_idle_motor_off: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && time_left == '0) |-> !motor_level)
    else $error("motor on with no running step");

  a_load_after_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> ($past(state) == ST_START && $past(mem_re)))
    else $error("step load without memory read");

endmodule

// ===== tb/sv/haptic_pattern_sequencer_top_test.sv =====
`timescale 1ns / 1ps

module haptic_pattern_sequencer_top_test;
  import hps_pkg::*;

  localparam int SLOTS = 32;
  localparam int HOLD_CYCLES = 250;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int PHASE_ITEMS = 300;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam logic [EFFECT_W-1:0] EFF_NONE = 2'd3;

  typedef struct packed {
    logic motor;
    logic busy;
  } levels_t;

  typedef struct packed {
    bit                  retune;
    logic [MODE_W-1:0]   md;
    logic [EFFECT_W-1:0] eff;
    logic [COUNT_W-1:0]  cnt;
    logic [LEN_W-1:0]    gap;
    bit                  typed;
    logic                motor;
    logic                busy;
  } cue_t;

  // retune: drain, then program tick 1 ms, warn 0 ms, expire 2 ms before this row
  localparam cue_t SCRIPT [0:24] = '{
    '{1'b0, MODE_TICK, EFF_TICK,   8'd0,   16'd0,      1'b1, 1'b0, 1'b0},
    '{1'b0, MODE_NONE, EFF_NONE,   8'd255, 16'hFFFF,   1'b1, 1'b0, 1'b0},
    '{1'b0, MODE_STOP, EFF_TICK,   8'd0,   16'd0,      1'b1, 1'b0, 1'b0},
    '{1'b0, MODE_PLAY, EFF_TICK,   8'd1,   16'd0,      1'b1, 1'b1, 1'b0},
    '{1'b0, MODE_TICK, EFF_TICK,   8'd0,   16'd0,      1'b1, 1'b1, 1'b0},
    '{1'b0, MODE_PLAY, EFF_WARN,   8'd1,   16'd0,      1'b1, 1'b1, 1'b1},
    '{1'b0, MODE_TICK, EFF_TICK,   8'd0,   16'd0,      1'b1, 1'b1, 1'b1},
    '{1'b0, MODE_PLAY, EFF_EXPIRE, 8'd255, 16'hFFFF,   1'b1, 1'b1, 1'b1},
    '{1'b0, MODE_PLAY, EFF_NONE,   8'd255, 16'hFFFF,   1'b1, 1'b0, 1'b1},
    '{1'b0, MODE_TICK, EFF_TICK,   8'd0,   16'd0,      1'b1, 1'b0, 1'b1},
    '{1'b0, MODE_PLAY, EFF_NONE,   8'd1,   16'hFFFF,   1'b1, 1'b0, 1'b0},
    '{1'b0, MODE_PLAY, EFF_TICK,   8'd0,   16'd7,      1'b1, 1'b0, 1'b0},
    '{1'b0, MODE_PLAY, EFF_WARN,   8'd2,   16'd0,      1'b1, 1'b1, 1'b1},
    '{1'b0, MODE_STOP, EFF_NONE,   8'hAA,  16'h5555,   1'b1, 1'b0, 1'b0},
    '{1'b1, MODE_PLAY, EFF_TICK,   8'd2,   16'd0,      1'b1, 1'b1, 1'b1},
    '{1'b0, MODE_TICK, EFF_TICK,   8'd0,   16'd0,      1'b1, 1'b1, 1'b0},
    '{1'b0, MODE_TICK, EFF_TICK,   8'd0,   16'd0,      1'b1, 1'b0, 1'b0},
    '{1'b0, MODE_TICK, EFF_TICK,   8'd0,   16'd0,      1'b1, 1'b0, 1'b0},
    '{1'b0, MODE_PLAY, EFF_WARN,   8'd3,   16'd1,      1'b1, 1'b0, 1'b1},
    '{1'b0, MODE_TICK, EFF_TICK,   8'd0,   16'd0,      1'b1, 1'b0, 1'b0},
    '{1'b0, MODE_TICK, EFF_TICK,   8'd0,   16'd0,      1'b1, 1'b0, 1'b0},
    '{1'b0, MODE_PLAY, EFF_EXPIRE, 8'd2,   16'd0,      1'b1, 1'b1, 1'b1},
    '{1'b0, MODE_TICK, EFF_TICK,   8'd0,   16'd0,      1'b1, 1'b1, 1'b1},
    '{1'b0, MODE_PLAY, EFF_TICK,   8'd1,   16'd0,      1'b0, 1'b0, 1'b0},
    '{1'b0, MODE_STOP, EFF_TICK,   8'd0,   16'd0,      1'b1, 1'b0, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MODE_W-1:0]    mode = '0;
  logic [EFFECT_W-1:0]  effect = '0;
  logic [COUNT_W-1:0]   repeat_count = '0;
  logic [LEN_W-1:0]     gap_length = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 motor_on;
  logic                 busy_res;
  logic                 wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [CFG_W-1:0]     wr_data = '0;

  // typed-in expectation travelling with the item
  bit   use_typed = 1'b0;
  logic typed_motor = 1'b0;
  logic typed_busy = 1'b0;

  bit steady = 1'b0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet = 0;

  // pattern model state
  logic [STEP_W-1:0] pat_mem [SLOTS];
  int unsigned       pat_cnt = 0;
  int unsigned       pat_pos = 0;
  logic [LEN_W-1:0]  ms_left = '0;
  logic              motor_lvl = 1'b0;
  logic [LEN_W-1:0]  tick_ms = TICK_DUR_RST;
  logic [LEN_W-1:0]  warn_ms = WARN_DUR_RST;
  logic [LEN_W-1:0]  expire_ms = EXPIRE_DUR_RST;
  bit                overflow = 1'b0;

  levels_t pending [$];
  int errors = 0;
  int items_in = 0;
  int results_seen = 0;
  int plays = 0;
  int full_lists = 0;
  int run_outs = 0;
  int counted = 0;

  haptic_pattern_sequencer_top #(.STEP_SLOTS(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .effect(effect),
    .repeat_count(repeat_count),
    .gap_length(gap_length),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .motor_on(motor_on),
    .busy_res(busy_res),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always #5 clk = ~clk;

  function automatic void add_step(input logic lvl, input logic [LEN_W-1:0] len);
    if (len != 0) begin
      if (pat_cnt < SLOTS) begin
        pat_mem[pat_cnt] = {lvl, len};
        pat_cnt = pat_cnt + 1;
      end else begin
        overflow = 1'b1;
      end
    end
  endfunction

  function automatic void start_next();
    if (pat_pos >= pat_cnt) begin
      motor_lvl = 1'b0;
      ms_left = '0;
    end else begin
      motor_lvl = pat_mem[pat_pos][STEP_W-1];
      ms_left = pat_mem[pat_pos][LEN_W-1:0];
      pat_pos = pat_pos + 1;
    end
  endfunction

  function automatic void apply_item(input logic [MODE_W-1:0] md,
                                     input logic [EFFECT_W-1:0] eff,
                                     input logic [COUNT_W-1:0] cnt,
                                     input logic [LEN_W-1:0] gap);
    case (md)
      MODE_TICK: begin
        if (ms_left != 0) begin
          ms_left = ms_left - 1'b1;
          if (ms_left == 0) begin
            if (pat_pos >= pat_cnt) run_outs++;
            start_next();
          end
        end
      end
      MODE_PLAY: begin
        pat_cnt = 0;
        pat_pos = 0;
        overflow = 1'b0;
        for (int i = 0; i < cnt; i++) begin
          case (eff)
            EFF_TICK: add_step(1'b1, tick_ms);
            EFF_WARN: begin
              add_step(1'b1, warn_ms);
              add_step(1'b0, warn_ms);
              add_step(1'b1, warn_ms);
            end
            EFF_EXPIRE: add_step(1'b1, expire_ms);
            default: ;
          endcase
          if (i + 1 < cnt) add_step(1'b0, gap);
        end
        start_next();
        plays++;
        if (overflow) full_lists++;
      end
      MODE_STOP: begin
        pat_cnt = 0;
        pat_pos = 0;
        ms_left = '0;
        motor_lvl = 1'b0;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : scoreboard
    levels_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending.size() == 0) begin
          $display("%0t: unexpected result motor_on %b busy_res %b", $time, motor_on,
                   busy_res);
          errors++;
        end else begin
          want = pending.pop_front();
          results_seen++;
          if (motor_on !== want.motor) begin
            $display("%0t: motor_on expected %b got %b", $time, want.motor, motor_on);
            errors++;
          end
          if (busy_res !== want.busy) begin
            $display("%0t: busy_res expected %b got %b", $time, want.busy, busy_res);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_item(mode, effect, repeat_count, gap_length);
        items_in++;
        if (use_typed) pending.push_back('{typed_motor, typed_busy});
        else pending.push_back('{motor_lvl, pat_pos < pat_cnt});
      end
    end
  end

  // result side: random back-pressure plus requested long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("haptic_pattern_sequencer_top test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic offer(input logic [MODE_W-1:0] md, input logic [EFFECT_W-1:0] eff,
                       input logic [COUNT_W-1:0] cnt, input logic [LEN_W-1:0] gap,
                       input bit typed, input logic t_motor, input logic t_busy);
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= md;
    effect <= eff;
    repeat_count <= cnt;
    gap_length <= gap;
    use_typed <= typed;
    typed_motor <= t_motor;
    typed_busy <= t_busy;
    do @(posedge clk); while (!in_ready);
    if (md != MODE_NONE) counted++;
  endtask

  task automatic offer_checked(input logic [MODE_W-1:0] md);
    offer(md, EFFECT_W'($urandom), COUNT_W'($urandom), LEN_W'($urandom), 1'b0, 1'b0,
          1'b0);
  endtask

  // hold until every result is in, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_durations(input logic [CFG_W-1:0] t, input logic [CFG_W-1:0] w,
                                 input logic [CFG_W-1:0] e);
    wr_en <= 1'b1;
    wr_index <= REG_TICK_DUR;
    wr_data <= t;
    @(posedge clk);
    wr_index <= REG_WARN_DUR;
    wr_data <= w;
    @(posedge clk);
    wr_index <= REG_EXPIRE_DUR;
    wr_data <= e;
    @(posedge clk);
    wr_en <= 1'b0;
    tick_ms = t;
    warn_ms = w;
    expire_ms = e;
  endtask

  // play with random content, then a run of ticks with the odd stop or junk item
  task automatic run_phase(input int n_items);
    int target;
    int ticks;
    int pick;
    logic [EFFECT_W-1:0] eff;
    logic [COUNT_W-1:0]  cnt;
    logic [LEN_W-1:0]    gap;
    target = counted + n_items;
    while (counted < target) begin
      eff = ($urandom_range(9) == 0) ? EFF_NONE : EFFECT_W'($urandom_range(2));
      pick = $urandom_range(19);
      if (pick == 0) cnt = COUNT_W'($urandom_range(255));
      else if (pick == 1) cnt = '0;
      else cnt = COUNT_W'($urandom_range(6, 1));
      gap = ($urandom_range(9) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(4));
      offer(MODE_PLAY, eff, cnt, gap, 1'b0, 1'b0, 1'b0);
      ticks = ($urandom_range(3) == 0) ? $urandom_range(8) : $urandom_range(60, 10);
      for (int j = 0; j < ticks; j++) begin
        pick = $urandom_range(99);
        if (pick < 4) offer_checked(MODE_STOP);
        else if (pick < 8) offer_checked(MODE_NONE);
        else offer_checked(MODE_TICK);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[k]) begin
      if (SCRIPT[k].retune) begin
        settle();
        write_durations(16'd1, 16'd0, 16'd2);
      end
      offer(SCRIPT[k].md, SCRIPT[k].eff, SCRIPT[k].cnt, SCRIPT[k].gap, SCRIPT[k].typed,
            SCRIPT[k].motor, SCRIPT[k].busy);
    end

    settle();
    write_durations(CFG_W'($urandom_range(3, 1)), CFG_W'($urandom_range(3, 1)),
                    CFG_W'($urandom_range(5, 1)));
    hold_asks <= hold_asks + 1;
    run_phase(PHASE_ITEMS);

    settle();
    write_durations('0, '0, '0);
    run_phase(PHASE_ITEMS);

    settle();
    write_durations('1, '1, '1);
    run_phase(PHASE_ITEMS);

    settle();
    write_durations(CFG_W'($urandom_range(4)), CFG_W'($urandom_range(4)),
                    CFG_W'($urandom_range(4)));
    steady <= 1'b1;
    run_phase(PHASE_ITEMS);
    steady <= 1'b0;

    settle();
    write_durations(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    run_phase(PHASE_ITEMS);

    settle();
    write_durations(CFG_W'($urandom_range(6, 1)), CFG_W'($urandom_range(6, 1)),
                    CFG_W'($urandom_range(6, 1)));
    hold_asks <= hold_asks + 1;
    run_phase(PHASE_ITEMS);

    settle();
    $display("Covered %0d items and %0d results over eight duration settings:",
             items_in, results_seen);
    $display("%0d plays, %0d with the step list full, %0d patterns run to the end",
             plays, full_lists, run_outs);
    if (errors == 0) begin
      $display("haptic_pattern_sequencer_top test passed");
    end else begin
      $display("haptic_pattern_sequencer_top test failed");
    end
    $finish;
  end

endmodule
